// ===== src/ambient_light_proximity_conversion_macros.svh =====
// Assertion macros shared by the checker of the light/proximity conversion block.
// No dependencies; include by bare file name.
`ifndef AMBIENT_LIGHT_PROXIMITY_CONVERSION_MACROS_SVH
`define AMBIENT_LIGHT_PROXIMITY_CONVERSION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ALPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alpc check failed");

// Next-cycle implication, disabled during reset.
`define ALPC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alpc check failed");

`endif

// ===== src/alpc_pkg.sv =====
// Shared types, constants and the microcode table of the light/proximity conversion.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package alpc_pkg;

   localparam int CH_W       = 16;
   localparam int COEF_W     = 16;
   localparam int STATUS_W   = 8;
   localparam int SHCTL_W    = 8;
   localparam int LIMIT_W    = 4;
   localparam int LUX_W      = 23;
   localparam int PROX_W     = 32;
   localparam int ACC_W      = 35;
   localparam int MUL_A_W    = 32;
   localparam int MUL_P_W    = 48;
   localparam int Q12_FRAC   = 12;
   localparam int LUX_SHIFT  = 20;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;

   // rsp_tdata layout
   localparam int RSP_LUX_LSB   = 0;
   localparam int RSP_PROX_LSB  = 23;
   localparam int RSP_CLOSE_BIT = 55;
   localparam int RSP_NEAR_BIT  = 56;
   localparam int RSP_FAR_BIT   = 57;
   // rsp_tuser layout
   localparam int USR_VALID_BIT = 0;
   localparam int USR_GAVE_BIT  = 1;

   // shift control byte
   localparam int SHCTL_LEFT_BIT = 7;
   localparam int SHCTL_AMT_W    = 7;
   localparam int SHIFT_IDX_W    = 5;

   localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LUX_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_THR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIM  = 3'd6;

   // register reset values
   localparam logic [COEF_W-1:0]  RST_COEF_B    = 16'd7627;
   localparam logic [COEF_W-1:0]  RST_COEF_C    = 16'd3056;
   localparam logic [COEF_W-1:0]  RST_COEF_D    = 16'd5288;
   localparam logic [COEF_W-1:0]  RST_LUX_SCALE = 16'd16532;
   localparam logic [CH_W-1:0]    RST_NEAR_THR  = 16'd150;
   localparam logic [CH_W-1:0]    RST_FAR_THR   = 16'd100;
   localparam logic [LIMIT_W-1:0] RST_RETRY_LIM = 4'd3;

   typedef struct packed {
      logic [COEF_W-1:0]  coef_b;
      logic [COEF_W-1:0]  coef_c;
      logic [COEF_W-1:0]  coef_d;
      logic [COEF_W-1:0]  lux_scale;
      logic [CH_W-1:0]    near_thr;
      logic [CH_W-1:0]    far_thr;
      logic [LIMIT_W-1:0] retry_limit;
   } csr_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_B_CH1,
      MUL_C_CH0,
      MUL_D_CH1,
      MUL_BEST_SCALE
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_T1,
      ACC_LOAD,
      ACC_SUB,
      ACC_MAX
   } acc_op_type;

   typedef enum logic {
      JC_NONE,
      JC_NOT_READY
   } jump_cond_type;

   typedef struct packed {
      mul_op_type         mul_op;
      acc_op_type         acc_op;
      jump_cond_type      cond;
      logic [STEP_W-1:0]  target;
      logic               last;
   } ucode_type;

   typedef struct packed {
      logic      load_in;
      logic      fire;
      ucode_type word;
   } seq_ctrl_type;

   typedef struct packed {
      logic ready;
      logic out_free;
   } dp_status_type;

   localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

   // Microprogram: build both lux terms, pick the larger, scale, then finish.
   // A not-ready poll skips straight to the finish step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{mul_op: MUL_NONE, acc_op: ACC_HOLD, cond: JC_NONE, target: '0, last: 1'b0};
      case (step)
         3'd0: begin
            w.mul_op = MUL_B_CH1;
            w.cond   = JC_NOT_READY;
            w.target = STEP_FINISH;
         end
         3'd1: begin
            w.mul_op = MUL_C_CH0;
            w.acc_op = ACC_T1;
         end
         3'd2: begin
            w.mul_op = MUL_D_CH1;
            w.acc_op = ACC_LOAD;
         end
         3'd3: w.acc_op = ACC_SUB;
         3'd4: w.acc_op = ACC_MAX;
         3'd5: w.mul_op = MUL_BEST_SCALE;
         3'd6: w.last = 1'b1;
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== src/alpc_csr.sv =====
// Configuration register file of the light/proximity conversion.
// Depends on alpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alpc_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [alpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [alpc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output alpc_pkg::csr_type                    csr
);

   alpc_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            alpc_pkg::CSR_COEF_B:    csr_in.coef_b    = csr_wdata;
            alpc_pkg::CSR_COEF_C:    csr_in.coef_c    = csr_wdata;
            alpc_pkg::CSR_COEF_D:    csr_in.coef_d    = csr_wdata;
            alpc_pkg::CSR_LUX_SCALE: csr_in.lux_scale = csr_wdata;
            alpc_pkg::CSR_NEAR_THR:  csr_in.near_thr  = csr_wdata;
            alpc_pkg::CSR_FAR_THR:   csr_in.far_thr   = csr_wdata;
            alpc_pkg::CSR_RETRY_LIM:
               csr_in.retry_limit = csr_wdata[alpc_pkg::LIMIT_W-1:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.coef_b      <= alpc_pkg::RST_COEF_B;
         csr_ff.coef_c      <= alpc_pkg::RST_COEF_C;
         csr_ff.coef_d      <= alpc_pkg::RST_COEF_D;
         csr_ff.lux_scale   <= alpc_pkg::RST_LUX_SCALE;
         csr_ff.near_thr    <= alpc_pkg::RST_NEAR_THR;
         csr_ff.far_thr     <= alpc_pkg::RST_FAR_THR;
         csr_ff.retry_limit <= alpc_pkg::RST_RETRY_LIM;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

// ===== src/alpc_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on alpc_pkg (microcode table and control types).
`timescale 1ns / 1ps
`default_nettype none

module alpc_sequencer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  alpc_pkg::dp_status_type   stat,
   output alpc_pkg::seq_ctrl_type    ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [alpc_pkg::STEP_W-1:0]   step_ff, step_in;
   alpc_pkg::ucode_type           cw;
   logic                          fire;

   assign cw = alpc_pkg::ucode_rom(step_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      // The finish step waits until the result register can take the transfer.
      fire     = (state_ff == ST_RUN) && !(cw.last && !stat.out_free);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (fire) begin
               if (cw.last) begin
                  state_in = ST_IDLE;
               end else if (cw.cond == alpc_pkg::JC_NOT_READY && !stat.ready) begin
                  step_in = cw.target;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign ctrl.load_in = req_tvalid && req_tready;
   assign ctrl.fire    = fire;
   assign ctrl.word    = cw;

endmodule

`default_nettype wire

// ===== src/alpc_datapath.sv =====
// Datapath: shared multiplier, signed accumulator, proximity shifter, retry and
// hysteresis state, and the result register. Depends on alpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alpc_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  alpc_pkg::seq_ctrl_type                ctrl,
   output alpc_pkg::dp_status_type               stat,
   input  alpc_pkg::csr_type                     csr,
   input  wire  [alpc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  [alpc_pkg::REQ_TUSER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [alpc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [alpc_pkg::RSP_TUSER_W-1:0]      rsp_tuser
);

   localparam int CH_W   = alpc_pkg::CH_W;
   localparam int ACC_W  = alpc_pkg::ACC_W;
   localparam int MA_W   = alpc_pkg::MUL_A_W;
   localparam int MP_W   = alpc_pkg::MUL_P_W;
   localparam int LUX_W  = alpc_pkg::LUX_W;
   localparam int LUX_SH = alpc_pkg::LUX_SHIFT;
   localparam int PROX_W = alpc_pkg::PROX_W;
   localparam int LIM_W  = alpc_pkg::LIMIT_W;

   // latched poll
   logic [CH_W-1:0]                  ch0_ff, ch1_ff, praw_ff;
   logic [alpc_pkg::SHCTL_W-1:0]     pctl_ff;
   logic                             ready_ff;

   // arithmetic
   logic [MA_W-1:0]                  mul_a;
   logic [alpc_pkg::COEF_W-1:0]      mul_b;
   logic [MP_W-1:0]                  mul_ff, mul_in;
   logic signed [ACC_W-1:0]          acc_ff, acc_in, t1_ff, t1_in;
   logic signed [ACC_W-1:0]          mul_ext, best;

   // finish step
   logic [alpc_pkg::SHCTL_AMT_W-1:0] amt;
   logic [PROX_W-1:0]                prox_ext, prox_val;
   logic [LUX_W-1:0]                 lux_val;
   logic [LIM_W-1:0]                 cnt_inc;
   logic                             gave, wnear, wfar;

   // control state
   logic [LIM_W-1:0]                 retry_ff, retry_in;
   logic                             close_ff, close_in;

   // result register
   logic                             out_vld_ff, out_vld_in;
   logic [alpc_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic [alpc_pkg::RSP_TUSER_W-1:0] out_user_ff, out_user_in;
   logic                             out_free, finish;

   assign out_free = !out_vld_ff || rsp_tready;
   assign finish   = ctrl.fire && ctrl.word.last;

   assign stat.ready    = ready_ff;
   assign stat.out_free = out_free;

   // hold the poll for the whole program
   always_ff @(posedge clock) begin
      if (ctrl.load_in) begin
         ch0_ff   <= req_tdata[CH_W-1:0];
         ch1_ff   <= req_tdata[2*CH_W-1:CH_W];
         praw_ff  <= req_tdata[3*CH_W-1:2*CH_W];
         pctl_ff  <= req_tdata[3*CH_W+alpc_pkg::SHCTL_W-1:3*CH_W];
         ready_ff <= req_tuser[0] || req_tuser[1];
      end
   end

   always_comb begin
      case (ctrl.word.mul_op)
         alpc_pkg::MUL_B_CH1: begin
            mul_a = {{(MA_W-CH_W){1'b0}}, ch1_ff};
            mul_b = csr.coef_b;
         end
         alpc_pkg::MUL_C_CH0: begin
            mul_a = {{(MA_W-CH_W){1'b0}}, ch0_ff};
            mul_b = csr.coef_c;
         end
         alpc_pkg::MUL_D_CH1: begin
            mul_a = {{(MA_W-CH_W){1'b0}}, ch1_ff};
            mul_b = csr.coef_d;
         end
         alpc_pkg::MUL_BEST_SCALE: begin
            mul_a = acc_ff[MA_W-1:0];
            mul_b = csr.lux_scale;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      mul_in = mul_ff;
      if (ctrl.fire && ctrl.word.mul_op != alpc_pkg::MUL_NONE) begin
         mul_in = mul_a * mul_b;
      end
   end

   assign mul_ext = {{(ACC_W-MA_W){1'b0}}, mul_ff[MA_W-1:0]};
   assign best    = (t1_ff > acc_ff) ? t1_ff : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      t1_in  = t1_ff;
      if (ctrl.fire) begin
         case (ctrl.word.acc_op)
            alpc_pkg::ACC_T1:
               acc_in = {{(ACC_W-CH_W-alpc_pkg::Q12_FRAC){1'b0}}, ch0_ff,
                         {alpc_pkg::Q12_FRAC{1'b0}}} - mul_ext;
            alpc_pkg::ACC_LOAD: begin
               t1_in  = acc_ff;
               acc_in = mul_ext;
            end
            alpc_pkg::ACC_SUB: acc_in = acc_ff - mul_ext;
            // larger term, clamped at zero
            alpc_pkg::ACC_MAX: acc_in = best[ACC_W-1] ? '0 : best;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      t1_ff  <= t1_in;
   end

   // proximity shift; amounts of 32 and up give zero
   assign amt      = pctl_ff[alpc_pkg::SHCTL_AMT_W-1:0];
   assign prox_ext = {{(PROX_W-CH_W){1'b0}}, praw_ff};

   always_comb begin
      if (|amt[alpc_pkg::SHCTL_AMT_W-1:alpc_pkg::SHIFT_IDX_W]) begin
         prox_val = '0;
      end else if (pctl_ff[alpc_pkg::SHCTL_LEFT_BIT]) begin
         prox_val = prox_ext << amt[alpc_pkg::SHIFT_IDX_W-1:0];
      end else begin
         prox_val = prox_ext >> amt[alpc_pkg::SHIFT_IDX_W-1:0];
      end
   end

   // scaled product back to Q.8, saturating
   assign lux_val = (|mul_ff[MP_W-1:LUX_SH+LUX_W]) ? alpc_pkg::LUX_MAX
                                                  : mul_ff[LUX_SH+LUX_W-1:LUX_SH];

   assign cnt_inc = retry_ff + 1'b1;

   always_comb begin
      retry_in    = retry_ff;
      close_in    = close_ff;
      gave        = 1'b0;
      wnear       = 1'b0;
      wfar        = 1'b0;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_user_in = out_user_ff;
      if (finish) begin
         if (!ready_ff) begin
            if (cnt_inc >= csr.retry_limit) begin
               gave     = 1'b1;
               retry_in = '0;
            end else begin
               retry_in = cnt_inc;
            end
         end else begin
            retry_in = '0;
            if (close_ff) begin
               if (prox_val < {{(PROX_W-CH_W){1'b0}}, csr.far_thr}) begin
                  close_in = 1'b0;
                  wfar     = 1'b1;
               end
            end else if (prox_val > {{(PROX_W-CH_W){1'b0}}, csr.near_thr}) begin
               close_in = 1'b1;
               wnear    = 1'b1;
            end
         end
         out_vld_in  = 1'b1;
         out_data_in = '0;
         if (ready_ff) begin
            out_data_in[alpc_pkg::RSP_LUX_LSB +: LUX_W]   = lux_val;
            out_data_in[alpc_pkg::RSP_PROX_LSB +: PROX_W] = prox_val;
         end
         out_data_in[alpc_pkg::RSP_CLOSE_BIT] = close_in;
         out_data_in[alpc_pkg::RSP_NEAR_BIT]  = wnear;
         out_data_in[alpc_pkg::RSP_FAR_BIT]   = wfar;
         out_user_in[alpc_pkg::USR_VALID_BIT] = ready_ff;
         out_user_in[alpc_pkg::USR_GAVE_BIT]  = gave;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff   <= '0;
         close_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         retry_ff   <= retry_in;
         close_ff   <= close_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

// ===== src/ambient_light_proximity_conversion.sv =====
// Top level of the ambient light and proximity conversion block.
// Depends on alpc_pkg, alpc_csr, alpc_sequencer and alpc_datapath.
//
// Each transfer on the req_ side is one sensor poll; each poll yields exactly one
// transfer on the rsp_ side. A poll with either valid bit set runs the full
// microprogram (two lux terms, max and clamp, scaling) on one shared 32x16
// multiplier; a poll with no valid bit jumps to the finish step. The finish step
// also waits while a previous result is still held in the output register and
// rsp_tready is low. req_tready is high only while the sequencer is idle, so a
// new poll is taken only once the last one has finished. The csr_ port writes
// the register named by csr_index (0 to 6) on every clock edge with csr_we high;
// write it only while no poll is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ambient_light_proximity_conversion (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // light_ch0[15:0], light_ch1[31:16], prox_raw[47:32], prox_shift_ctl[55:48]
   input  wire  [alpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // status_byte[7:0]
   input  wire  [alpc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // lux_q8[22:0], proximity[54:23], is_close[55], went_near[56], went_far[57],
   // zero[63:58]
   output logic [alpc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // sample_valid[0], gave_up[1]
   output logic [alpc_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  wire                                  csr_we,
   input  wire  [alpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [alpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   alpc_pkg::csr_type       csr;
   alpc_pkg::seq_ctrl_type  ctrl;
   alpc_pkg::dp_status_type stat;

   alpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   alpc_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   alpc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .csr        (csr),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== src/alpc_checker.sv =====
// Port-level checks of the light/proximity conversion, bound to the top level.
// Depends on alpc_pkg and ambient_light_proximity_conversion_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ambient_light_proximity_conversion_macros.svh"

module alpc_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [alpc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire [alpc_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // a stalled result holds
   `ALPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a poll is never both converted and reported as given up
   `ALPC_ASSERT_IMP(a_valid_gave_excl, clock, reset, rsp_tvalid, !(rsp_tuser[alpc_pkg::USR_VALID_BIT] && rsp_tuser[alpc_pkg::USR_GAVE_BIT]))

   // events agree with the reported hysteresis state
   `ALPC_ASSERT_IMP(a_event_state, clock, reset, rsp_tvalid, (!rsp_tdata[alpc_pkg::RSP_NEAR_BIT] || rsp_tdata[alpc_pkg::RSP_CLOSE_BIT]) && (!rsp_tdata[alpc_pkg::RSP_FAR_BIT] || !rsp_tdata[alpc_pkg::RSP_CLOSE_BIT]))

   // a not-ready poll carries no lux or proximity
   `ALPC_ASSERT_IMP(a_notready_zero, clock, reset, rsp_tvalid && !rsp_tuser[alpc_pkg::USR_VALID_BIT], rsp_tdata[alpc_pkg::RSP_CLOSE_BIT-1:0] == '0)

   // the block is busy right after taking a poll
   `ALPC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind ambient_light_proximity_conversion alpc_checker u_alpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
